@@ sv/ufn_pkg.sv @@
// ----------------------------------------------------------------------------
// ufn_pkg
// types, constants and symbol classification for the utf-8 accent folder
// ----------------------------------------------------------------------------
package ufn_pkg;

    localparam int BundleDepth = 4;
    localparam int BundleCntW  = 3;
    localparam int PaddrW      = 3;

    localparam logic [PaddrW-1:0] RegAddrOutCapacity = 3'd0;

    localparam logic [8:0] CapReset = 9'd72;
    localparam logic [8:0] CapMax   = 9'd256;
    localparam logic [8:0] CapMin   = 9'd1;

    localparam logic [1:0] SYM_NONE = 2'd0;
    localparam logic [1:0] SYM_SEP  = 2'd1;
    localparam logic [1:0] SYM_CHAR = 2'd2;

    localparam logic [6:0] SepChar  = 7'h20;
    localparam logic [6:0] TermChar = 7'h00;

    localparam logic [7:0] ByteC3   = 8'hC3;
    localparam logic [7:0] ByteE2   = 8'hE2;
    localparam logic [7:0] Byte80   = 8'h80;
    localparam logic [7:0] Byte98   = 8'h98;
    localparam logic [7:0] Byte99   = 8'h99;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] ch;
    } t_sym;

    typedef struct packed {
        logic       last;
        logic [6:0] ch;
    } t_res;

    typedef struct packed {
        logic                  load;
        logic [BundleCntW-1:0] count;
        t_res [BundleDepth-1:0] ent;
    } t_bundle;

    function automatic t_sym mk_sym(input logic [1:0] kind, input logic [6:0] ch);
        t_sym s;
        s.kind = kind;
        s.ch   = ch;
        return s;
    endfunction

    function automatic t_sym ascii_sym(input logic [7:0] b);
        t_sym s;
        s = mk_sym(SYM_SEP, SepChar);
        if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A)) begin
            s = mk_sym(SYM_CHAR, b[6:0]);
        end else if (b >= 8'h41 && b <= 8'h5A) begin
            s = mk_sym(SYM_CHAR, b[6:0] | 7'h20);
        end else if (b == 8'h27 || b == 8'h60) begin
            s = mk_sym(SYM_NONE, SepChar);
        end
        return s;
    endfunction

    // sequence length from a lead byte, 1 for anything that is not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        if (b[7:5] == 3'b110) n = 3'd2;
        else if (b[7:4] == 4'b1110) n = 3'd3;
        else if (b[7:3] == 5'b11110) n = 3'd4;
        return n;
    endfunction

    // accent table over the low six bits of the continuation byte
    function automatic t_sym accent_sym(input logic [5:0] idx);
        t_sym s;
        s = mk_sym(SYM_SEP, SepChar);
        case (idx[4:0])
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: s = mk_sym(SYM_CHAR, 7'h61);
            5'd7:                               s = mk_sym(SYM_CHAR, 7'h63);
            5'd8, 5'd9, 5'd10, 5'd11:           s = mk_sym(SYM_CHAR, 7'h65);
            5'd12, 5'd13, 5'd14, 5'd15:         s = mk_sym(SYM_CHAR, 7'h69);
            5'd17:                              s = mk_sym(SYM_CHAR, 7'h6E);
            5'd18, 5'd19, 5'd20, 5'd21, 5'd22:  s = mk_sym(SYM_CHAR, 7'h6F);
            5'd25, 5'd26, 5'd27, 5'd28:         s = mk_sym(SYM_CHAR, 7'h75);
            5'd29:                              s = mk_sym(SYM_CHAR, 7'h79);
            default:                            s = mk_sym(SYM_SEP, SepChar);
        endcase
        if (idx == 6'd63) s = mk_sym(SYM_CHAR, 7'h79);
        return s;
    endfunction

    function automatic t_sym seq2_sym(input logic [7:0] a, input logic [7:0] b);
        t_sym s;
        s = mk_sym(SYM_SEP, SepChar);
        if (a == ByteC3 && b[7:6] == 2'b10) s = accent_sym(b[5:0]);
        return s;
    endfunction

    function automatic t_sym seq3_sym(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
        t_sym s;
        s = mk_sym(SYM_SEP, SepChar);
        if (a == ByteE2 && b == Byte80 && (c == Byte98 || c == Byte99)) begin
            s = mk_sym(SYM_NONE, SepChar);
        end
        return s;
    endfunction

endpackage

@@ sv/ufn_cfg.sv @@
// ----------------------------------------------------------------------------
// ufn_cfg
// register port holding the output capacity
// ----------------------------------------------------------------------------
module ufn_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ufn_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [8:0]                 o_capacity
);

    logic [8:0] r_cap;
    logic       w_hit;

    assign w_hit  = (paddr == ufn_pkg::RegAddrOutCapacity);
    assign pready = 1'b1;
    assign prdata = w_hit ? {23'd0, r_cap} : 32'd0;
    assign o_capacity = r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ufn_pkg::CapReset;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_cap <= pwdata[8:0];
        end
    end

endmodule

@@ sv/ufn_core.sv @@
// ----------------------------------------------------------------------------
// ufn_core
// input register, sequence state and folding logic building one result bundle
// ----------------------------------------------------------------------------
module ufn_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    input  logic [8:0]       i_capacity,
    input  logic             i_free,
    output ufn_pkg::t_bundle o_bundle
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_eot;
    logic [2:0][7:0]     r_seq;
    logic [1:0]          r_cnt;
    logic [2:0]          r_exp;
    logic [7:0]          r_chars;
    logic                r_gap;
    logic                r_any;

    logic [2:0][7:0]     n_seq;
    logic [1:0]          n_cnt;
    logic [2:0]          n_exp;
    logic [7:0]          n_chars;
    logic                n_gap;
    logic                n_any;

    logic                w_go;
    logic [8:0]          w_cap;
    ufn_pkg::t_sym [2:0] w_sym;
    ufn_pkg::t_res [ufn_pkg::BundleDepth-1:0] w_ent;
    logic [ufn_pkg::BundleCntW-1:0] w_pos;

    assign w_go    = r_in_valid && i_free;
    assign o_stall = r_in_valid && !i_free;

    always_comb begin
        w_cap = i_capacity;
        if (i_capacity == 9'd0) w_cap = ufn_pkg::CapMin;
        else if (i_capacity > ufn_pkg::CapMax) w_cap = ufn_pkg::CapMax;
    end

    always_comb begin
        logic [7:0] b;
        logic       pair;
        logic [7:0] chars;
        logic       gap;
        logic       any;
        b     = r_in_byte;
        pair  = 1'b0;
        n_seq = r_seq;
        n_cnt = r_cnt;
        n_exp = r_exp;
        for (int k = 0; k < 3; k++) begin
            w_sym[k] = ufn_pkg::mk_sym(ufn_pkg::SYM_NONE, ufn_pkg::SepChar);
        end

        // byte path
        if (b != 8'd0) begin
            if (r_cnt == 2'd0) begin
                if (!b[7]) begin
                    w_sym[0] = ufn_pkg::ascii_sym(b);
                end else if (ufn_pkg::lead_len(b) == 3'd1) begin
                    w_sym[0] = ufn_pkg::mk_sym(ufn_pkg::SYM_SEP, ufn_pkg::SepChar);
                end else begin
                    n_seq[0] = b;
                    n_cnt    = 2'd1;
                    n_exp    = ufn_pkg::lead_len(b);
                end
            end else if (({1'b0, r_cnt} + 3'd1 >= r_exp) || r_cnt == 2'd3) begin
                case (r_cnt)
                    2'd1:    w_sym[0] = ufn_pkg::seq2_sym(r_seq[0], b);
                    2'd2:    w_sym[0] = ufn_pkg::seq3_sym(r_seq[0], r_seq[1], b);
                    default: w_sym[0] = ufn_pkg::mk_sym(ufn_pkg::SYM_SEP, ufn_pkg::SepChar);
                endcase
                n_cnt = 2'd0;
                n_exp = 3'd0;
            end else begin
                n_seq[r_cnt] = b;
                n_cnt        = r_cnt + 2'd1;
            end
        end

        // end of text inside a sequence: lead becomes a gap, the rest is refolded
        if (r_in_eot) begin
            if (n_cnt != 2'd0) begin
                w_sym[0] = ufn_pkg::mk_sym(ufn_pkg::SYM_SEP, ufn_pkg::SepChar);
            end
            if (n_cnt >= 2'd2) begin
                if (!n_seq[1][7]) begin
                    w_sym[1] = ufn_pkg::ascii_sym(n_seq[1]);
                end else if (ufn_pkg::lead_len(n_seq[1]) == 3'd2 && n_cnt == 2'd3) begin
                    w_sym[1] = ufn_pkg::seq2_sym(n_seq[1], n_seq[2]);
                    pair     = 1'b1;
                end else begin
                    w_sym[1] = ufn_pkg::mk_sym(ufn_pkg::SYM_SEP, ufn_pkg::SepChar);
                end
            end
            if (n_cnt == 2'd3 && !pair) begin
                w_sym[2] = n_seq[2][7]
                         ? ufn_pkg::mk_sym(ufn_pkg::SYM_SEP, ufn_pkg::SepChar)
                         : ufn_pkg::ascii_sym(n_seq[2]);
            end
        end

        // separator collapsing and capacity limit
        chars = r_chars;
        gap   = r_gap;
        any   = r_any;
        w_pos = '0;
        for (int k = 0; k < ufn_pkg::BundleDepth; k++) begin
            w_ent[k] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            case (w_sym[k].kind)
                ufn_pkg::SYM_SEP: begin
                    if (any) gap = 1'b1;
                end
                ufn_pkg::SYM_CHAR: begin
                    if (gap) begin
                        if ({2'd0, chars} + 10'd2 < {1'b0, w_cap}) begin
                            w_ent[w_pos[1:0]] = {1'b0, ufn_pkg::SepChar};
                            w_pos = w_pos + 3'd1;
                            w_ent[w_pos[1:0]] = {1'b0, w_sym[k].ch};
                            w_pos = w_pos + 3'd1;
                            chars = chars + 8'd2;
                            gap   = 1'b0;
                            any   = 1'b1;
                        end
                    end else if ({2'd0, chars} + 10'd1 < {1'b0, w_cap}) begin
                        w_ent[w_pos[1:0]] = {1'b0, w_sym[k].ch};
                        w_pos = w_pos + 3'd1;
                        chars = chars + 8'd1;
                        any   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        n_chars = chars;
        n_gap   = gap;
        n_any   = any;
        if (r_in_eot) begin
            w_ent[w_pos[1:0]] = {1'b1, ufn_pkg::TermChar};
            w_pos   = w_pos + 3'd1;
            n_cnt   = 2'd0;
            n_exp   = 3'd0;
            n_chars = 8'd0;
            n_gap   = 1'b0;
            n_any   = 1'b0;
        end
    end

    assign o_bundle.load  = w_go;
    assign o_bundle.count = w_pos;
    assign o_bundle.ent   = w_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_exp      <= 3'd0;
            r_chars    <= 8'd0;
            r_gap      <= 1'b0;
            r_any      <= 1'b0;
        end else begin
            if (!o_stall) r_in_valid <= i_valid;
            if (w_go) begin
                r_cnt   <= n_cnt;
                r_exp   <= n_exp;
                r_chars <= n_chars;
                r_gap   <= n_gap;
                r_any   <= n_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
        if (w_go) r_seq <= n_seq;
    end

endmodule

@@ sv/ufn_outq.sv @@
// ----------------------------------------------------------------------------
// ufn_outq
// result register: holds one bundle and hands out its items in order
// ----------------------------------------------------------------------------
module ufn_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ufn_pkg::t_bundle i_bundle,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [6:0]       o_out_char,
    output logic             o_out_last
);

    ufn_pkg::t_res [ufn_pkg::BundleDepth-1:0] r_ent;
    logic [ufn_pkg::BundleCntW-1:0]           r_cnt;
    logic                                     w_take;

    assign o_valid    = (r_cnt != '0);
    assign w_take     = o_valid && !i_stall;
    assign o_free     = (r_cnt == '0) || (r_cnt == 3'd1 && w_take);
    assign o_out_char = r_ent[0].ch;
    assign o_out_last = r_ent[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_bundle.load) begin
            r_cnt <= i_bundle.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle.load) begin
            r_ent <= i_bundle.ent;
        end else if (w_take) begin
            for (int k = 0; k < ufn_pkg::BundleDepth - 1; k++) begin
                r_ent[k] <= r_ent[k + 1];
            end
        end
    end

endmodule

@@ sv/utf8_accent_fold_normalizer.sv @@
// ----------------------------------------------------------------------------
// utf8_accent_fold_normalizer
// folds utf-8 text bytes into lowercase ascii words with single spaces
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_text_byte, i_end_of_text
//   result    out        o_valid / i_stall   o_out_char, o_out_last
//   config    in         psel / penable      paddr, pwdata, prdata
//
// the input register feeds the result register through the folding logic. a
// new item every cycle while each item yields at most one result and i_stall
// is low, since the result register hands out one item per cycle. an item
// yielding more than one result stalls the input until all but the last
// have gone out (up to four results at end of text). reset is synchronous
// and clears all text state. result-side stalls reach the input through o_stall.
// ----------------------------------------------------------------------------
module utf8_accent_fold_normalizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_text_byte,
    input  logic                       i_end_of_text,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [6:0]                 o_out_char,
    output logic                       o_out_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ufn_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [8:0]       w_capacity;
    logic             w_free;
    ufn_pkg::t_bundle w_bundle;

    ufn_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    ufn_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_capacity    (w_capacity),
        .i_free        (w_free),
        .o_bundle      (w_bundle)
    );

    ufn_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bundle   (w_bundle),
        .o_free     (w_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

    a_term_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> o_out_char == ufn_pkg::TermChar)
        else $error("terminator item carries a nonzero char");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bundle.load |-> w_free && w_bundle.count <= 3'd4)
        else $error("bundle loaded into a busy result register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
